### src/nilo_pkg.sv
// Package for the newline index / offset locator.
// Shared sizes, operation codes and status codes.
// No dependencies.
`default_nettype none

package nilo_pkg;

	// Table and counter sizes
	localparam int MAX_NEWLINES = 1024;
	localparam int OFFSET_BITS  = 16;
	localparam int ADDR_W       = $clog2(MAX_NEWLINES);
	localparam int CNT_W        = $clog2(MAX_NEWLINES + 1);
	localparam int LINE_W       = 11;
	localparam int COL_W        = 16;
	localparam int OP_W         = 2;
	localparam int BYTE_W       = 8;
	localparam int STATUS_W     = 2;

	localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'd10;

	// Operation codes
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BEYOND   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

endpackage

`default_nettype wire

### src/newline_index_offset_locator.sv
// Top level of the newline index / offset locator.
// Uses nilo_pkg and one nilo_ram for the newline position table.
//
//   channel | signals                                  | dir
//   in      | in_valid, in_stall, op, text_byte,       | into block
//           | query_offset                             |
//   out     | out_valid, out_stall, line_number,       | out of block
//           | column_number, status                    |
//
// Clear and byte items never stall the input; bytes can stream back to back.
// A query binary-searches the newline table with one RAM read port:
// each search step reads in S_SRCH and compares in S_CMP, and a final S_FIX
// step fixes the column, skipped when the offset lands on the first line.
// Error queries (overflow, offset past end) skip the search.
// Reset (arst_n, async) empties the text; table contents stay undefined.
// A stalled result holds in the output register; bytes and clears are still
// taken meanwhile, a new query waits at its end for the output slot.
`default_nettype none

module newline_index_offset_locator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [nilo_pkg::OP_W-1:0]     op,
	input  wire logic [nilo_pkg::BYTE_W-1:0]   text_byte,
	input  wire logic [nilo_pkg::OFFSET_BITS-1:0] query_offset,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [nilo_pkg::LINE_W-1:0]        line_number,
	output logic [nilo_pkg::COL_W-1:0]         column_number,
	output logic [nilo_pkg::STATUS_W-1:0]      status
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SRCH = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_FIX  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	localparam int AW = nilo_pkg::ADDR_W;
	localparam int CW = nilo_pkg::CNT_W;
	localparam int OW = nilo_pkg::OFFSET_BITS;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [OW-1:0] length_q;
	logic          ovf_q;

	logic [CW-1:0] lo_q, hi_q, mid_q;
	logic [OW-1:0] offset_q;
	logic [nilo_pkg::LINE_W-1:0]   res_line_q;
	logic [nilo_pkg::COL_W-1:0]    res_col_q;
	logic [nilo_pkg::STATUS_W-1:0] res_status_q;

	logic                          out_valid_q;
	logic [nilo_pkg::LINE_W-1:0]   out_line_q;
	logic [nilo_pkg::COL_W-1:0]    out_col_q;
	logic [nilo_pkg::STATUS_W-1:0] out_status_q;

	logic          in_xfer;
	logic          slot_free;
	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid;
	logic [CW-1:0] lo_dec;
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [OW-1:0] ram_rdata;
	logic          is_nl;
	logic          wr_nl;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// Search midpoint and predecessor index
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CW:1];
	assign lo_dec  = lo_q - CW'(1);

	// Byte append: write a newline position when there is room
	assign is_nl = (text_byte == nilo_pkg::NEWLINE_CHAR);
	assign wr_nl = in_xfer && (op == nilo_pkg::OP_BYTE) && !ovf_q && is_nl
		&& (length_q != {OW{1'b1}}) && (count_q != CW'(nilo_pkg::MAX_NEWLINES));

	// RAM port address: write in idle, search reads in S_SRCH
	assign ram_we = wr_nl;
	always_comb begin
		case (state_q)
			S_SRCH:  ram_addr = (lo_q < hi_q) ? mid[AW-1:0] : lo_dec[AW-1:0];
			default: ram_addr = count_q[AW-1:0];
		endcase
	end

	nilo_ram #(
		.WIDTH (OW),
		.DEPTH (nilo_pkg::MAX_NEWLINES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (length_q),
		.rdata (ram_rdata)
	);

	// Text state and search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			length_q <= '0;
			ovf_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						case (op)
							nilo_pkg::OP_CLEAR: begin
								count_q  <= '0;
								length_q <= '0;
								ovf_q    <= 1'b0;
							end
							nilo_pkg::OP_BYTE: begin
								if (!ovf_q) begin
									if (length_q == {OW{1'b1}}) begin
										ovf_q <= 1'b1;
									end else if (is_nl && count_q
										== CW'(nilo_pkg::MAX_NEWLINES)) begin
										ovf_q <= 1'b1;
									end else begin
										length_q <= length_q + OW'(1);
										if (is_nl) begin
											count_q <= count_q + CW'(1);
										end
									end
								end
							end
							nilo_pkg::OP_QUERY: begin
								if (ovf_q || query_offset > length_q) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_SRCH;
								end
							end
							default: ;
						endcase
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						state_q <= S_CMP;
					end else if (lo_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_FIX;
					end
				end
				S_CMP:  state_q <= S_SRCH;
				S_FIX:  state_q <= S_DONE;
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Search bounds and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				lo_q     <= '0;
				hi_q     <= count_q;
				offset_q <= query_offset;
				res_line_q <= '0;
				res_col_q  <= '0;
				if (ovf_q) begin
					res_status_q <= nilo_pkg::ST_OVERFLOW;
				end else if (query_offset > length_q) begin
					res_status_q <= nilo_pkg::ST_BEYOND;
				end else begin
					res_status_q <= nilo_pkg::ST_OK;
				end
			end
			S_SRCH: begin
				mid_q      <= mid;
				res_line_q <= nilo_pkg::LINE_W'(lo_q);
				res_col_q  <= nilo_pkg::COL_W'(offset_q);
			end
			S_CMP: begin
				if (ram_rdata < offset_q) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			S_FIX: begin
				res_col_q <= nilo_pkg::COL_W'(offset_q - (ram_rdata + OW'(1)));
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && slot_free) begin
			out_line_q   <= res_line_q;
			out_col_q    <= res_col_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign line_number   = out_line_q;
	assign column_number = out_col_q;
	assign status        = out_status_q;

endmodule

`default_nettype wire

### src/nilo_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module nilo_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port, registered read; a read during a write returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Testbench for newline_index_offset_locator: streams texts and offset queries
// and checks every line/column answer against an in-bench location predictor.
// Depends on nilo_pkg and the newline_index_offset_locator RTL.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// op 3 has no meaning; the block must drop it
	localparam logic [nilo_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned LENGTH_MAX = (1 << nilo_pkg::OFFSET_BITS) - 1;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [nilo_pkg::OFFSET_BITS-1:0] offset;
		logic [nilo_pkg::LINE_W-1:0]      line;
		logic [nilo_pkg::COL_W-1:0]       col;
		logic [nilo_pkg::STATUS_W-1:0]    st;
	} location_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [nilo_pkg::OP_W-1:0] op = nilo_pkg::OP_CLEAR;
	logic [nilo_pkg::BYTE_W-1:0] text_byte = '0;
	logic [nilo_pkg::OFFSET_BITS-1:0] query_offset = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [nilo_pkg::LINE_W-1:0] line_number;
	logic [nilo_pkg::COL_W-1:0] column_number;
	logic [nilo_pkg::STATUS_W-1:0] status;

	// calm: no idling on either side
	logic calm = 1'b0;
	int stall_left = 0;

	// predicted text state
	logic [nilo_pkg::OFFSET_BITS-1:0] nl_pos [nilo_pkg::MAX_NEWLINES];
	int unsigned nl_count = 0;
	int unsigned text_len = 0;
	bit text_overflowed = 1'b0;

	location_t pending_locations [$];

	int transfers_in = 0;
	int locations_checked = 0;
	int overflow_answers = 0;
	int beyond_answers = 0;
	int mismatches = 0;

	newline_index_offset_locator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.text_byte    (text_byte),
		.query_offset (query_offset),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_number  (line_number),
		.column_number(column_number),
		.status       (status)
	);

	always #5 clk = ~clk;

	// Predictor: text state update for one byte
	function automatic void append_text_byte(input logic [nilo_pkg::BYTE_W-1:0] b);
		if (text_overflowed)
			return;
		if (text_len >= LENGTH_MAX) begin
			text_overflowed = 1'b1;
			return;
		end
		if (b == nilo_pkg::NEWLINE_CHAR) begin
			if (nl_count >= nilo_pkg::MAX_NEWLINES) begin
				text_overflowed = 1'b1;
				return;
			end
			nl_pos[nl_count] = nilo_pkg::OFFSET_BITS'(text_len);
			nl_count++;
		end
		text_len++;
	endfunction

	// Predictor: line and column holding an offset
	function automatic location_t locate_offset(
			input logic [nilo_pkg::OFFSET_BITS-1:0] off);
		location_t r;
		int unsigned idx;
		int unsigned start;
		r = '0;
		r.offset = off;
		if (text_overflowed) begin
			r.st = nilo_pkg::ST_OVERFLOW;
		end else if (off > text_len) begin
			r.st = nilo_pkg::ST_BEYOND;
		end else begin
			idx = 0;
			while (idx < nl_count && nl_pos[idx] < off)
				idx++;
			start = (idx == 0) ? 0 : nl_pos[idx - 1] + 1;
			r.line = nilo_pkg::LINE_W'(idx);
			r.col = nilo_pkg::COL_W'(off - start);
			r.st = nilo_pkg::ST_OK;
		end
		return r;
	endfunction

	// Drive one item, wait for its transfer, then update the prediction
	task automatic send_item(input logic [nilo_pkg::OP_W-1:0] o,
			input logic [nilo_pkg::BYTE_W-1:0] b,
			input logic [nilo_pkg::OFFSET_BITS-1:0] q);
		int gap;
		location_t loc;
		gap = 0;
		if (!calm && $urandom_range(0, 11) == 0)
			gap = $urandom_range(1, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		text_byte <= b;
		query_offset <= q;
		do @(posedge clk); while (in_stall);
		case (o)
			nilo_pkg::OP_CLEAR: begin
				nl_count = 0;
				text_len = 0;
				text_overflowed = 1'b0;
				transfers_in++;
			end
			nilo_pkg::OP_BYTE: begin
				append_text_byte(b);
				transfers_in++;
			end
			nilo_pkg::OP_QUERY: begin
				loc = locate_offset(q);
				if (loc.st == nilo_pkg::ST_OVERFLOW)
					overflow_answers++;
				if (loc.st == nilo_pkg::ST_BEYOND)
					beyond_answers++;
				pending_locations.insert(pending_locations.size(), loc);
				transfers_in++;
			end
			default: ;
		endcase
	endtask

	task automatic send_byte(input logic [nilo_pkg::BYTE_W-1:0] b);
		send_item(nilo_pkg::OP_BYTE, b, nilo_pkg::OFFSET_BITS'($urandom));
	endtask

	task automatic send_query(input logic [nilo_pkg::OFFSET_BITS-1:0] q);
		send_item(nilo_pkg::OP_QUERY, nilo_pkg::BYTE_W'($urandom), q);
	endtask

	task automatic send_clear();
		send_item(nilo_pkg::OP_CLEAR, nilo_pkg::BYTE_W'($urandom),
			nilo_pkg::OFFSET_BITS'($urandom));
	endtask

	// Hold the sender until every predicted location has come back
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		while (pending_locations.size() != 0)
			@(posedge clk);
	endtask

	// Empty text, extreme bytes, newline and empty lines, sentinel, beyond end
	task automatic test_directed();
		send_clear();
		send_query(16'd0);
		send_query(16'd1);
		send_byte(8'd97);
		send_byte(8'd98);
		send_byte(nilo_pkg::NEWLINE_CHAR);
		send_byte(8'd99);
		send_byte(nilo_pkg::NEWLINE_CHAR);
		send_byte(nilo_pkg::NEWLINE_CHAR);
		send_byte(8'd255);
		send_byte(8'd0);
		send_item(OP_UNUSED, 8'hFF, 16'hFFFF);
		send_query(16'd0);
		send_query(16'd2);
		send_query(16'd3);
		send_query(16'd5);
		send_query(16'd6);
		send_query(16'd8);
		send_query(16'd9);
		send_query(16'hFFFF);
		send_clear();
		send_query(16'd0);
		send_query(16'd4);
	endtask

	// Fill the newline table, use a byte after it is full, then overflow it
	task automatic test_table_full();
		send_clear();
		repeat (nilo_pkg::MAX_NEWLINES) send_byte(nilo_pkg::NEWLINE_CHAR);
		send_query(16'd0);
		send_query(16'd512);
		send_query(16'd1023);
		send_query(16'd1024);
		send_byte(8'd97);
		send_query(16'd1025);
		send_query(16'd1026);
		send_byte(nilo_pkg::NEWLINE_CHAR);
		send_query(16'd0);
		send_byte(8'd98);
		send_query(16'd1025);
		send_clear();
		send_query(16'd0);
	endtask

	// Well-formed texts with random content, queries mostly inside the text
	task automatic test_random_texts(input int n_items, input bit may_idle);
		int sent;
		int len;
		int i;
		int k;
		int pick;
		logic [nilo_pkg::BYTE_W-1:0] b;
		logic [nilo_pkg::OFFSET_BITS-1:0] q;
		sent = 0;
		while (sent < n_items) begin
			if (may_idle && $urandom_range(0, 19) == 0)
				calm <= ~calm;
			if ($urandom_range(0, 7) != 0) begin
				send_clear();
				sent++;
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 30);
			for (i = 0; i < len; i++) begin
				b = ($urandom_range(0, 3) == 0) ? nilo_pkg::NEWLINE_CHAR
					: nilo_pkg::BYTE_W'($urandom);
				send_byte(b);
				if ($urandom_range(0, 39) == 0)
					send_item(OP_UNUSED, nilo_pkg::BYTE_W'($urandom),
						nilo_pkg::OFFSET_BITS'($urandom));
			end
			sent += len;
			k = $urandom_range(1, 6);
			for (i = 0; i < k; i++) begin
				pick = $urandom_range(0, 19);
				if (pick < 14)
					q = nilo_pkg::OFFSET_BITS'($urandom_range(0, text_len));
				else if (pick < 17)
					q = nilo_pkg::OFFSET_BITS'(text_len + $urandom_range(1, 3));
				else if (pick < 19)
					q = nilo_pkg::OFFSET_BITS'($urandom);
				else
					q = '1;
				send_query(q);
			end
			sent += k;
			if (may_idle && $urandom_range(0, 49) == 0)
				wait_until_drained();
		end
	endtask

	// Receiver: random stall bursts unless calm
	always @(posedge clk) begin
		if (calm) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 18);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result checker: each transfer out against the oldest prediction
	always @(posedge clk) begin
		location_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_locations.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result: line %0d col %0d status %0d",
						$realtime, line_number, column_number, status);
			end else begin
				want = pending_locations.pop_front();
				locations_checked++;
				if (line_number !== want.line || column_number !== want.col ||
						status !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: offset %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
							$realtime, want.offset, want.line, want.col, want.st,
							line_number, column_number, status);
				end
			end
		end
	end

	// Main sequence
	initial begin
		int waited;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		wait_until_drained();
		test_random_texts(500, 1'b1);
		wait_until_drained();
		calm <= 1'b1;
		test_random_texts(250, 1'b0);
		in_valid <= 1'b0;
		waited = 0;
		while (pending_locations.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_locations.size() != 0) begin
			$display("%0d predicted locations never came back", pending_locations.size());
			mismatches += pending_locations.size();
		end
		$display("%0d transfers in, %0d locations checked (%0d overflowed, %0d past end)",
			transfers_in, locations_checked, overflow_answers, beyond_answers);
		$display("directed, table full, random texts with and without idling; %0d mismatches",
			mismatches);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("timeout with %0d locations outstanding", pending_locations.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
